// ----- sv/schl_pkg.sv -----
// ============================================================================
// schl_pkg: shared definitions for the switch-case hash lookup
// Command, key type and status codes, field widths and parameter defaults.
// ============================================================================
package schl_pkg;

    // Field widths
    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 2;
    localparam int TYPE_W   = 2;
    localparam int STATUS_W = 2;

    // The bucket hash consumes the key one byte per cycle.
    localparam int DIGIT_W  = 8;

    // Parameter defaults
    localparam int DEF_MAX_ENTRIES  = 64;
    localparam int DEF_BUCKET_COUNT = 128;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    // Key type codes
    localparam logic [TYPE_W-1:0] KT_BOOL = 2'd0;
    localparam logic [TYPE_W-1:0] KT_INT  = 2'd1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEFAULT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_TYPE = 2'd3;

endpackage

// ----- sv/switch_case_hash_lookup.sv -----
// ============================================================================
// switch_case_hash_lookup
// Switch-case jump table held as a chained hash in two synchronous memories.
// ============================================================================
// One request is handled at a time and every request returns one result. An
// add reads its bucket head and prepends the new entry; a lookup reads the
// bucket head and then walks the chain one entry at a time. When
// BUCKET_COUNT is not a power of two, add and lookup first take one
// remainder step per DIGIT_W-bit digit of the key. The chain walk is set
// by the entry memory: one read per visited entry. A clear, and likewise
// the sweep after reset, writes every bucket head once, during which no
// request is accepted; configuration writes are taken at any time.
// A finished result waits in the output register while the block is free
// to accept the next request.
module switch_case_hash_lookup #(
    parameter int MAX_ENTRIES  = schl_pkg::DEF_MAX_ENTRIES,
    parameter int BUCKET_COUNT = schl_pkg::DEF_BUCKET_COUNT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration
    input  logic                                 i_cfg_wr_en,
    input  logic signed [schl_pkg::VALUE_W-1:0]  i_cfg_wr_data,
    // Request channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [schl_pkg::CMD_W-1:0]           i_cmd,
    input  logic [schl_pkg::TYPE_W-1:0]          i_key_type,
    input  logic signed [schl_pkg::VALUE_W-1:0]  i_key_value,
    input  logic signed [schl_pkg::VALUE_W-1:0]  i_entry_target,
    // Result channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [schl_pkg::VALUE_W-1:0]  o_target,
    output logic [schl_pkg::STATUS_W-1:0]        o_status
);
    import schl_pkg::*;

    localparam int  IDX_W    = $clog2(MAX_ENTRIES);
    localparam int  PTR_W    = $clog2(MAX_ENTRIES + 1);
    localparam int  BKT_W    = $clog2(BUCKET_COUNT);
    localparam bit  BKT_POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;
    localparam int  DIGITS   = VALUE_W / DIGIT_W;
    localparam int  DCNT_W   = $clog2(DIGITS);
    localparam logic [BKT_W:0]   BKT_LIM  = (BKT_W + 1)'(BUCKET_COUNT);
    localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(BUCKET_COUNT - 1);
    localparam logic [PTR_W-1:0] CNT_MAX  = PTR_W'(MAX_ENTRIES);

    // One stored case entry; the link is the next entry number plus one.
    typedef struct packed {
        logic               is_int;
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] target;
        logic [PTR_W-1:0]   link;
    } t_entry;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_CMP,
        S_HOLD
    } t_state;

    // Eight remainder steps: shift one byte into the bucket remainder.
    function automatic logic [BKT_W-1:0] mod_digit(input logic [BKT_W-1:0] rem,
                                                   input logic [DIGIT_W-1:0] dig);
        logic [BKT_W:0]   acc;
        logic [BKT_W-1:0] r;
        r = rem;
        for (int k = DIGIT_W - 1; k >= 0; k--) begin
            acc = {r, dig[k]};
            if (acc >= BKT_LIM) begin
                acc = acc - BKT_LIM;
            end
            r = acc[BKT_W-1:0];
        end
        return r;
    endfunction

    // Registers
    t_state                  r_state;
    logic [PTR_W-1:0]        r_count;
    logic [BKT_W-1:0]        r_sweep;
    logic                    r_clr_pend;
    logic [CMD_W-1:0]        r_cmd;
    logic                    r_is_int;
    logic [VALUE_W-1:0]      r_val;
    logic [VALUE_W-1:0]      r_tgt;
    logic [VALUE_W-1:0]      r_shift;
    logic [DCNT_W-1:0]       r_dcnt;
    logic [BKT_W-1:0]        r_bkt;
    logic [VALUE_W-1:0]      r_default_offset;
    logic                    r_o_valid;
    logic [VALUE_W-1:0]      r_o_target;
    logic [STATUS_W-1:0]     r_o_status;
    logic [VALUE_W-1:0]      r_pend_target;
    logic [STATUS_W-1:0]     r_pend_status;

    // Memories and their registered read data
    logic [PTR_W-1:0]        hd_mem [BUCKET_COUNT];
    t_entry                  ent_mem [MAX_ENTRIES];
    logic [PTR_W-1:0]        r_hd_q;
    t_entry                  r_ent_q;

    // Combinational signals
    logic                    accept;
    logic                    out_free;
    logic                    type_ok;
    logic [VALUE_W-1:0]      norm_val;
    logic [BKT_W-1:0]        n_bkt;
    logic [IDX_W-1:0]        ent_raddr;
    logic [PTR_W-1:0]        walk_link;
    logic [PTR_W-1:0]        walk_prev;
    logic                    hd_we;
    logic [BKT_W-1:0]        hd_waddr;
    logic [PTR_W-1:0]        hd_wdata;
    logic                    ent_we;
    t_entry                  ent_wdata;
    logic                    done;
    logic [VALUE_W-1:0]      res_target;
    logic [STATUS_W-1:0]     res_status;
    t_state                  n_state;

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_o_valid;
    assign o_target = r_o_target;
    assign o_status = r_o_status;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_o_valid || !i_stall;
    assign type_ok  = (i_key_type == KT_BOOL) || (i_key_type == KT_INT);
    assign norm_val = (i_key_type == KT_BOOL) ? {{(VALUE_W-1){1'b0}}, |i_key_value}
                                              : i_key_value;

    // Link followed on a miss: the head pointer first, then the entry links.
    assign walk_link = (r_state == S_HEAD) ? r_hd_q : r_ent_q.link;
    assign walk_prev = walk_link - 1'b1;

    // Control decisions, memory addresses and the result of a finishing step.
    always_comb begin
        n_state    = r_state;
        n_bkt      = r_bkt;
        ent_raddr  = '0;
        hd_we      = 1'b0;
        hd_waddr   = r_bkt;
        hd_wdata   = '0;
        ent_we     = 1'b0;
        ent_wdata  = '{is_int: r_is_int, value: r_val, target: r_tgt, link: r_hd_q};
        done       = 1'b0;
        res_target = '0;
        res_status = ST_DONE;
        case (r_state)
            S_SWEEP: begin
                hd_we    = 1'b1;
                hd_waddr = r_sweep;
                if (r_sweep == BKT_LAST) begin
                    done    = r_clr_pend;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_bkt = BKT_POW2 ? norm_val[BKT_W-1:0] : '0;
                    case (i_cmd)
                        CMD_CLEAR: begin
                            n_state = S_SWEEP;
                        end
                        CMD_ADD: begin
                            if (!type_ok) begin
                                done       = 1'b1;
                                res_status = ST_BAD_TYPE;
                            end else if (r_count >= CNT_MAX) begin
                                done       = 1'b1;
                                res_status = ST_FULL;
                            end else begin
                                n_state = BKT_POW2 ? S_HEAD : S_HASH;
                            end
                        end
                        CMD_LOOKUP: begin
                            if (!type_ok || (r_count == '0)) begin
                                done       = 1'b1;
                                res_target = r_default_offset;
                                res_status = ST_DEFAULT;
                            end else begin
                                n_state = BKT_POW2 ? S_HEAD : S_HASH;
                            end
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_HASH: begin
                n_bkt = mod_digit(r_bkt, r_shift[VALUE_W-1 -: DIGIT_W]);
                if (r_dcnt == DCNT_W'(DIGITS - 1)) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD, S_CMP: begin
                if ((r_state == S_HEAD) && (r_cmd == CMD_ADD)) begin
                    // Prepend the new entry to its bucket chain.
                    ent_we   = 1'b1;
                    hd_we    = 1'b1;
                    hd_wdata = r_count + 1'b1;
                    done     = 1'b1;
                end else if ((r_state == S_CMP) && (r_ent_q.is_int == r_is_int)
                             && (r_ent_q.value == r_val)) begin
                    done       = 1'b1;
                    res_target = r_ent_q.target;
                end else if (walk_link == '0) begin
                    done       = 1'b1;
                    res_target = r_default_offset;
                    res_status = ST_DEFAULT;
                end else begin
                    ent_raddr = walk_prev[IDX_W-1:0];
                    n_state   = S_CMP;
                end
            end
            S_HOLD: begin
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Bucket head memory.
    always_ff @(posedge i_clk) begin
        if (hd_we) begin
            hd_mem[hd_waddr] <= hd_wdata;
        end
        r_hd_q <= hd_mem[n_bkt];
    end

    // Entry memory.
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[r_count[IDX_W-1:0]] <= ent_wdata;
        end
        r_ent_q <= ent_mem[ent_raddr];
    end

    // State, request registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_SWEEP;
            r_count          <= '0;
            r_sweep          <= '0;
            r_clr_pend       <= 1'b0;
            r_default_offset <= '0;
            r_o_valid        <= 1'b0;
        end else begin
            r_bkt <= n_bkt;

            if (i_cfg_wr_en) begin
                r_default_offset <= i_cfg_wr_data;
            end

            if (accept) begin
                r_cmd    <= i_cmd;
                r_is_int <= i_key_type[0];
                r_val    <= norm_val;
                r_tgt    <= i_entry_target;
                r_shift  <= norm_val;
                r_dcnt   <= '0;
                if (i_cmd == CMD_CLEAR) begin
                    r_count    <= '0;
                    r_sweep    <= '0;
                    r_clr_pend <= 1'b1;
                end
            end

            if (r_state == S_SWEEP) begin
                r_sweep <= r_sweep + 1'b1;
            end

            if (r_state == S_HASH) begin
                r_shift <= r_shift << DIGIT_W;
                r_dcnt  <= r_dcnt + 1'b1;
            end

            if (ent_we) begin
                r_count <= r_count + 1'b1;
            end

            // Result hand-off: straight to the output register when it is
            // free, else parked until the consumer takes the previous one.
            if (out_free && r_o_valid) begin
                r_o_valid <= 1'b0;
            end
            if (done) begin
                if (out_free) begin
                    r_o_valid  <= 1'b1;
                    r_o_target <= res_target;
                    r_o_status <= res_status;
                    r_state    <= S_IDLE;
                end else begin
                    r_pend_target <= res_target;
                    r_pend_status <= res_status;
                    r_state       <= S_HOLD;
                end
            end else if (r_state == S_HOLD) begin
                if (out_free) begin
                    r_o_valid  <= 1'b1;
                    r_o_target <= r_pend_target;
                    r_o_status <= r_pend_status;
                    r_state    <= S_IDLE;
                end
            end else begin
                r_state <= n_state;
            end
        end
    end

`ifndef SYNTH
    // The entry count never passes the table size.
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("entry count exceeds table size");

    // An add only reaches the chain update with room left in the table.
    a_add_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HEAD) && (r_cmd == CMD_ADD) |-> r_count < CNT_MAX)
        else $error("add reached chain update on a full table");

    // An accepted clear empties the table and starts the head sweep.
    a_clear_sweep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_cmd == CMD_CLEAR) |=> (r_count == '0) && (r_state == S_SWEEP))
        else $error("clear did not reset the table");

    // A waiting result is never overwritten by a new one.
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && i_stall |=> r_o_valid && $stable(r_o_target)
                                  && $stable(r_o_status))
        else $error("stalled result was overwritten");
`endif

endmodule
